// ===== design/y2r_pkg.sv =====
package y2r_pkg;

    localparam int BYTE_W      = 8;
    localparam int COEF_W      = 16;
    localparam int COEF_SET_W  = 48;
    localparam int SAMPLE_W    = 17;
    localparam int PROD_W      = 33;
    localparam int SUM_W       = 35;
    localparam int CHAN_W      = 10;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = 3;
    localparam int FMT_W       = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int NUM_CHAN    = 3;

    localparam logic [FMT_W-1:0] FMT_ARGB  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_BGRA  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB24 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_BGR24 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_R210  = 3'd4;
    localparam logic [FMT_W-1:0] FMT_R10K  = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ORDER  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_FORMAT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHROMA_MODE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_COEFS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_COEFS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_COEFS    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_OFFSETS = 3'd6;

    localparam logic ORDER_UYVY     = 1'b1;
    localparam logic CHROMA_AVERAGE = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_PACKED24 = 3'd3;
    localparam logic [CNT_W-1:0] COUNT_PACKED32 = 3'd4;

    localparam logic [CHAN_W-1:0] TOP_8BIT  = 10'd255;
    localparam logic [CHAN_W-1:0] TOP_10BIT = 10'd1023;

    localparam logic [COEF_SET_W-1:0] COEFS_RESET   = 48'd256;
    localparam logic [COEF_SET_W-1:0] OFFSETS_RESET = 48'd0;

    typedef struct packed {
        logic [BYTE_W-1:0] luma;
        logic [BYTE_W-1:0] cb;
        logic [BYTE_W-1:0] cr;
        logic              line_last;
        logic              last_of_run;
    } job_t;

    typedef struct packed {
        logic source_order;
        logic chroma_mode;
    } front_cfg_t;

    typedef struct packed {
        logic [COEF_SET_W-1:0] red_coefs;
        logic [COEF_SET_W-1:0] green_coefs;
        logic [COEF_SET_W-1:0] blue_coefs;
        logic [COEF_SET_W-1:0] input_offsets;
        logic [FMT_W-1:0]      dest_format;
    } back_cfg_t;

endpackage

// ===== design/y2r_front.sv =====
module y2r_front
    import y2r_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  front_cfg_t        cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] first_byte,
    input  logic [BYTE_W-1:0] second_byte,
    input  logic [BYTE_W-1:0] third_byte,
    input  logic [BYTE_W-1:0] fourth_byte,
    input  logic              line_end,
    output logic              job_valid,
    input  logic              job_ready,
    output job_t              job
);

    // Pending pixel jobs of the held item: bit 0 held pixel, bit 1 first pixel,
    // bit 2 second pixel. The lowest set bit goes out next.
    logic [2:0]        mask_reg, mask_next;
    logic [2:0]        mask_left;
    logic              pending_reg, pending_next;
    logic [BYTE_W-1:0] held_luma_reg, held_cb_reg, held_cr_reg;
    logic [BYTE_W-1:0] a_luma_reg, a_cb_reg, a_cr_reg;
    logic [BYTE_W-1:0] y0_reg, y1_reg, cb_reg, cr_reg;
    logic              le_reg;
    logic [BYTE_W-1:0] y0, y1, u, v;
    logic [BYTE_W:0]   sum_cb, sum_cr;
    logic              push, accept, hold_second;

    always_comb
    begin
        if (cfg.source_order == ORDER_UYVY)
        begin
            u  = first_byte;
            y0 = second_byte;
            v  = third_byte;
            y1 = fourth_byte;
        end
        else
        begin
            y0 = first_byte;
            u  = second_byte;
            y1 = third_byte;
            v  = fourth_byte;
        end
    end

    assign sum_cb      = {1'b0, held_cb_reg} + {1'b0, u};
    assign sum_cr      = {1'b0, held_cr_reg} + {1'b0, v};
    assign hold_second = (cfg.chroma_mode == CHROMA_AVERAGE) && !line_end;

    assign job_valid = (mask_reg != 3'd0);
    assign push      = job_valid && job_ready;
    assign mask_left = mask_reg & (mask_reg - 3'd1);
    assign in_ready  = push ? (mask_left == 3'd0) : !job_valid;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        job.last_of_run = (mask_left == 3'd0);
        if (mask_reg[0])
        begin
            job.luma      = a_luma_reg;
            job.cb        = a_cb_reg;
            job.cr        = a_cr_reg;
            job.line_last = 1'b0;
        end
        else if (mask_reg[1])
        begin
            job.luma      = y0_reg;
            job.cb        = cb_reg;
            job.cr        = cr_reg;
            job.line_last = 1'b0;
        end
        else
        begin
            job.luma      = y1_reg;
            job.cb        = cb_reg;
            job.cr        = cr_reg;
            job.line_last = le_reg;
        end
    end

    always_comb
    begin
        mask_next    = push ? mask_left : mask_reg;
        pending_next = pending_reg;
        if (accept)
        begin
            mask_next    = {!hold_second, 1'b1, pending_reg};
            pending_next = hold_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= 3'd0;
            pending_reg <= 1'b0;
        end
        else
        begin
            mask_reg    <= mask_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_luma_reg <= held_luma_reg;
            a_cb_reg   <= sum_cb[BYTE_W:1];
            a_cr_reg   <= sum_cr[BYTE_W:1];
            y0_reg     <= y0;
            y1_reg     <= y1;
            cb_reg     <= u;
            cr_reg     <= v;
            le_reg     <= line_end;
            if (hold_second)
            begin
                held_luma_reg <= y1;
                held_cb_reg   <= u;
                held_cr_reg   <= v;
            end
        end
    end

endmodule

// ===== design/y2r_queue.sv =====
module y2r_queue
    import y2r_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] FULL_COUNT = CNT_W_Q'(DEPTH);

    job_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W_Q'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W_Q'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/y2r_back.sv =====
module y2r_back
    import y2r_pkg::*;
#(
    parameter int COEF_FRACTION_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  back_cfg_t         cfg,
    input  logic              job_valid,
    output logic              job_ready,
    input  job_t              job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] pixel_word,
    output logic [CNT_W-1:0]  byte_count,
    output logic              last_of_run,
    output logic              line_last
);

    function automatic logic signed [COEF_W-1:0] field16(logic [COEF_SET_W-1:0] w, int k);
        return w[k*COEF_W +: COEF_W];
    endfunction

    logic                       advance;
    logic signed [SAMPLE_W-1:0] samp_next [NUM_CHAN];
    logic signed [SAMPLE_W-1:0] samp_reg [NUM_CHAN];
    logic                       s1_valid_reg, s1_line_reg, s1_last_reg;
    logic signed [PROD_W-1:0]   prod_next [NUM_CHAN][NUM_CHAN];
    logic signed [PROD_W-1:0]   prod_reg [NUM_CHAN][NUM_CHAN];
    logic                       s2_valid_reg, s2_line_reg, s2_last_reg;
    logic signed [SUM_W-1:0]    quot_next [NUM_CHAN];
    logic signed [SUM_W-1:0]    quot_reg [NUM_CHAN];
    logic                       s3_valid_reg, s3_line_reg, s3_last_reg;
    logic [CHAN_W-1:0]          chan [NUM_CHAN];
    logic [CHAN_W-1:0]          top;
    logic                       ten_bit;
    logic [WORD_W-1:0]          word_next;
    logic [CNT_W-1:0]           count_next;
    logic                       out_valid_reg;
    logic [WORD_W-1:0]          word_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       last_reg, line_reg;
    logic [COEF_SET_W-1:0]      coef_set [NUM_CHAN];

    assign advance   = !out_valid_reg || out_ready;
    assign job_ready = advance;

    assign coef_set[0] = cfg.red_coefs;
    assign coef_set[1] = cfg.green_coefs;
    assign coef_set[2] = cfg.blue_coefs;

    always_comb
    begin
        samp_next[0] = $signed({9'd0, job.luma}) + $signed({cfg.input_offsets[15], cfg.input_offsets[15:0]});
        samp_next[1] = $signed({9'd0, job.cb}) + $signed({cfg.input_offsets[31], cfg.input_offsets[31:16]});
        samp_next[2] = $signed({9'd0, job.cr}) + $signed({cfg.input_offsets[47], cfg.input_offsets[47:32]});
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            for (int k = 0; k < NUM_CHAN; k++)
            begin
                prod_next[c][k] = field16(coef_set[c], k) * samp_reg[k];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            quot_next[c] = (SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                            + SUM_W'(prod_reg[c][2])) >>> COEF_FRACTION_BITS;
        end
    end

    assign ten_bit = (cfg.dest_format == FMT_R210) || (cfg.dest_format == FMT_R10K);
    assign top     = ten_bit ? TOP_10BIT : TOP_8BIT;

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (quot_reg[c] < 0)
            begin
                chan[c] = '0;
            end
            else if (quot_reg[c] > $signed({{(SUM_W - CHAN_W){1'b0}}, top}))
            begin
                chan[c] = top;
            end
            else
            begin
                chan[c] = quot_reg[c][CHAN_W-1:0];
            end
        end
    end

    always_comb
    begin
        count_next = COUNT_PACKED32;
        case (cfg.dest_format)
            FMT_BGRA:
            begin
                word_next = {chan[2][7:0], chan[1][7:0], chan[0][7:0], 8'd0};
            end
            FMT_RGB24:
            begin
                word_next  = {chan[0][7:0], chan[1][7:0], chan[2][7:0], 8'd0};
                count_next = COUNT_PACKED24;
            end
            FMT_BGR24:
            begin
                word_next  = {chan[2][7:0], chan[1][7:0], chan[0][7:0], 8'd0};
                count_next = COUNT_PACKED24;
            end
            FMT_R210:
            begin
                word_next = {2'd0, chan[0], chan[1], chan[2]};
            end
            FMT_R10K:
            begin
                word_next = {chan[0], chan[1], chan[2], 2'd0};
            end
            default:
            begin
                word_next = {8'd0, chan[0][7:0], chan[1][7:0], chan[2][7:0]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            samp_reg    <= samp_next;
            s1_line_reg <= job.line_last;
            s1_last_reg <= job.last_of_run;
            prod_reg    <= prod_next;
            s2_line_reg <= s1_line_reg;
            s2_last_reg <= s1_last_reg;
            quot_reg    <= quot_next;
            s3_line_reg <= s2_line_reg;
            s3_last_reg <= s2_last_reg;
            word_reg    <= word_next;
            count_reg   <= count_next;
            line_reg    <= s3_line_reg;
            last_reg    <= s3_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_word  = word_reg;
    assign byte_count  = count_reg;
    assign last_of_run = last_reg;
    assign line_last   = line_reg;

endmodule

// ===== design/yuv422_to_rgb_converter_unit.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    first_byte .. fourth_byte, line_end
// out      out_valid / out_ready  pixel_word, byte_count, last_of_run, line_last
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
// A macropixel gives its first pixel, its second unless held, and any held
// pixel it releases. The single result port, one pixel per cycle unless
// stalled, sets the rate; pixels pass sample, product, quotient, output regs.
// Reset clears the control state only; there is no clearing pass.
// A stalled output holds the back end while the front keeps filling the queue.
module yuv422_to_rgb_converter_unit
    import y2r_pkg::*;
#(
    parameter int COEF_FRACTION_BITS = 8,
    parameter int QUEUE_DEPTH        = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      first_byte,
    input  logic [BYTE_W-1:0]      second_byte,
    input  logic [BYTE_W-1:0]      third_byte,
    input  logic [BYTE_W-1:0]      fourth_byte,
    input  logic                   line_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [WORD_W-1:0]      pixel_word,
    output logic [CNT_W-1:0]       byte_count,
    output logic                   last_of_run,
    output logic                   line_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COEF_SET_W-1:0]  cfg_data
);

    logic                  source_order_reg;
    logic [FMT_W-1:0]      dest_format_reg;
    logic                  chroma_mode_reg;
    logic [COEF_SET_W-1:0] red_coefs_reg, green_coefs_reg, blue_coefs_reg;
    logic [COEF_SET_W-1:0] input_offsets_reg;
    logic                  cfg_write;
    front_cfg_t            front_cfg;
    back_cfg_t             back_cfg;
    logic                  push_valid, push_ready, pop_valid, pop_ready;
    job_t                  push_job, pop_job;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_order_reg  <= 1'b0;
            dest_format_reg   <= FMT_ARGB;
            chroma_mode_reg   <= 1'b0;
            red_coefs_reg     <= COEFS_RESET;
            green_coefs_reg   <= COEFS_RESET;
            blue_coefs_reg    <= COEFS_RESET;
            input_offsets_reg <= OFFSETS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_ORDER:  source_order_reg  <= cfg_data[0];
                REG_DEST_FORMAT:   dest_format_reg   <= cfg_data[FMT_W-1:0];
                REG_CHROMA_MODE:   chroma_mode_reg   <= cfg_data[0];
                REG_RED_COEFS:     red_coefs_reg     <= cfg_data;
                REG_GREEN_COEFS:   green_coefs_reg   <= cfg_data;
                REG_BLUE_COEFS:    blue_coefs_reg    <= cfg_data;
                REG_INPUT_OFFSETS: input_offsets_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign front_cfg.source_order = source_order_reg;
    assign front_cfg.chroma_mode  = chroma_mode_reg;

    assign back_cfg.red_coefs     = red_coefs_reg;
    assign back_cfg.green_coefs   = green_coefs_reg;
    assign back_cfg.blue_coefs    = blue_coefs_reg;
    assign back_cfg.input_offsets = input_offsets_reg;
    assign back_cfg.dest_format   = dest_format_reg;

    y2r_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (front_cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .third_byte  (third_byte),
        .fourth_byte (fourth_byte),
        .line_end    (line_end),
        .job_valid   (push_valid),
        .job_ready   (push_ready),
        .job         (push_job)
    );

    y2r_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    y2r_back #(
        .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (back_cfg),
        .job_valid   (pop_valid),
        .job_ready   (pop_ready),
        .job         (pop_job),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_word  (pixel_word),
        .byte_count  (byte_count),
        .last_of_run (last_of_run),
        .line_last   (line_last)
    );

    // The byte count must follow the packing format of the word it comes with.
    a_count_matches_format: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((byte_count == COUNT_PACKED24) ==
                       ((dest_format_reg == FMT_RGB24) || (dest_format_reg == FMT_BGR24))))
        else $error("byte count does not match the packing format");

    // The final pixel of a line always closes the run of its macropixel.
    a_line_last_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_last) |-> last_of_run)
        else $error("line end seen on a pixel that does not close its run");

    // The R10k layout leaves its two low bits clear.
    a_r10k_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (dest_format_reg == FMT_R10K)) |-> (pixel_word[1:0] == 2'd0))
        else $error("R10k word has low bits set");

    // While the queue is full the front must not be able to take a new macropixel
    // unless its current one is already finished.
    a_front_waits_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |-> !in_ready)
        else $error("front accepted a request while its pixel job was stalled");

endmodule

// ===== tb/yuv422_to_rgb_converter_unit_tb.sv =====
`timescale 1ns / 100ps

module yuv422_to_rgb_converter_unit_tb;
    import y2r_pkg::*;

    localparam int FRACTION_BITS = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [FMT_W-1:0] FMT_UNUSED = 3'd7;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  count;
        logic              run_end;
        logic              line_flag;
    } rgb_pixel_t;

    class pixel_scoreboard;
        logic                  source_order;
        logic                  chroma_mode;
        logic [FMT_W-1:0]      dest_format;
        logic [COEF_SET_W-1:0] red_coefs;
        logic [COEF_SET_W-1:0] green_coefs;
        logic [COEF_SET_W-1:0] blue_coefs;
        logic [COEF_SET_W-1:0] input_offsets;
        logic [BYTE_W-1:0]     held_luma;
        logic [BYTE_W-1:0]     held_cb;
        logic [BYTE_W-1:0]     held_cr;
        logic                  pair_pending;
        rgb_pixel_t            expected_pixels[$];
        int                    errors;
        int                    macropixels;
        int                    pixels;

        function new();
            source_order  = 1'b0;
            chroma_mode   = 1'b0;
            dest_format   = FMT_ARGB;
            red_coefs     = COEFS_RESET;
            green_coefs   = COEFS_RESET;
            blue_coefs    = COEFS_RESET;
            input_offsets = OFFSETS_RESET;
            held_luma     = '0;
            held_cb       = '0;
            held_cr       = '0;
            pair_pending  = 1'b0;
            errors        = 0;
            macropixels   = 0;
            pixels        = 0;
        endfunction

        function void apply_reg(logic [CFG_INDEX_W-1:0] index, logic [COEF_SET_W-1:0] data);
            case (index)
                REG_SOURCE_ORDER:  source_order  = data[0];
                REG_DEST_FORMAT:   dest_format   = data[FMT_W-1:0];
                REG_CHROMA_MODE:   chroma_mode   = data[0];
                REG_RED_COEFS:     red_coefs     = data;
                REG_GREEN_COEFS:   green_coefs   = data;
                REG_BLUE_COEFS:    blue_coefs    = data;
                REG_INPUT_OFFSETS: input_offsets = data;
                default: ;
            endcase
        endfunction

        function logic [CHAN_W-1:0] mix(logic [COEF_SET_W-1:0] coefs,
                                        longint y, longint u, longint v);
            longint sum;
            longint top;
            top = (dest_format == FMT_R210 || dest_format == FMT_R10K) ?
                  longint'(TOP_10BIT) : longint'(TOP_8BIT);
            sum = longint'($signed(coefs[15:0])) * y
                + longint'($signed(coefs[31:16])) * u
                + longint'($signed(coefs[47:32])) * v;
            sum = sum >>> FRACTION_BITS;
            if (sum < 0)
                sum = 0;
            if (sum > top)
                sum = top;
            return CHAN_W'(sum);
        endfunction

        function void push_pixel(logic [BYTE_W-1:0] luma, logic [BYTE_W-1:0] cb,
                                 logic [BYTE_W-1:0] cr, logic line_flag);
            longint            ys;
            longint            us;
            longint            vs;
            logic [CHAN_W-1:0] r;
            logic [CHAN_W-1:0] g;
            logic [CHAN_W-1:0] b;
            rgb_pixel_t        px;
            ys = longint'(luma) + longint'($signed(input_offsets[15:0]));
            us = longint'(cb) + longint'($signed(input_offsets[31:16]));
            vs = longint'(cr) + longint'($signed(input_offsets[47:32]));
            r = mix(red_coefs, ys, us, vs);
            g = mix(green_coefs, ys, us, vs);
            b = mix(blue_coefs, ys, us, vs);
            px.count = COUNT_PACKED32;
            case (dest_format)
                FMT_BGRA:  px.word = {b[7:0], g[7:0], r[7:0], 8'h00};
                FMT_RGB24:
                begin
                    px.word  = {r[7:0], g[7:0], b[7:0], 8'h00};
                    px.count = COUNT_PACKED24;
                end
                FMT_BGR24:
                begin
                    px.word  = {b[7:0], g[7:0], r[7:0], 8'h00};
                    px.count = COUNT_PACKED24;
                end
                FMT_R210:  px.word = {2'b00, r, g, b};
                FMT_R10K:  px.word = {r, g, b, 2'b00};
                default:   px.word = {8'h00, r[7:0], g[7:0], b[7:0]};
            endcase
            px.run_end   = 1'b0;
            px.line_flag = line_flag;
            expected_pixels.push_back(px);
        endfunction

        function void predict_macropixel(logic [BYTE_W-1:0] b0, logic [BYTE_W-1:0] b1,
                                         logic [BYTE_W-1:0] b2, logic [BYTE_W-1:0] b3,
                                         logic le);
            logic [BYTE_W-1:0] y0;
            logic [BYTE_W-1:0] y1;
            logic [BYTE_W-1:0] u;
            logic [BYTE_W-1:0] v;
            logic [BYTE_W:0]   sum_cb;
            logic [BYTE_W:0]   sum_cr;
            if (source_order == ORDER_UYVY)
            begin
                u  = b0;
                y0 = b1;
                v  = b2;
                y1 = b3;
            end
            else
            begin
                y0 = b0;
                u  = b1;
                y1 = b2;
                v  = b3;
            end
            if (pair_pending)
            begin
                sum_cb = held_cb + u;
                sum_cr = held_cr + v;
                push_pixel(held_luma, sum_cb[BYTE_W:1], sum_cr[BYTE_W:1], 1'b0);
                pair_pending = 1'b0;
            end
            push_pixel(y0, u, v, 1'b0);
            if (chroma_mode == CHROMA_AVERAGE && !le)
            begin
                held_luma    = y1;
                held_cb      = u;
                held_cr      = v;
                pair_pending = 1'b1;
            end
            else
            begin
                push_pixel(y1, u, v, le);
            end
            expected_pixels[expected_pixels.size()-1].run_end = 1'b1;
            macropixels++;
        endfunction

        function void check_pixel(logic [WORD_W-1:0] word, logic [CNT_W-1:0] count,
                                  logic run_end, logic line_flag);
            rgb_pixel_t px;
            pixels++;
            if (expected_pixels.size() == 0)
            begin
                $error("pixel_word 0x%08h arrived with no pixel expected", word);
                errors++;
                return;
            end
            px = expected_pixels.pop_front();
            if (word !== px.word)
            begin
                $error("pixel_word: expected 0x%08h, got 0x%08h", px.word, word);
                errors++;
            end
            if (count !== px.count)
            begin
                $error("byte_count: expected %0d, got %0d", px.count, count);
                errors++;
            end
            if (run_end !== px.run_end)
            begin
                $error("last_of_run: expected %0b, got %0b", px.run_end, run_end);
                errors++;
            end
            if (line_flag !== px.line_flag)
            begin
                $error("line_last: expected %0b, got %0b", px.line_flag, line_flag);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [BYTE_W-1:0]      first_byte = '0;
    logic [BYTE_W-1:0]      second_byte = '0;
    logic [BYTE_W-1:0]      third_byte = '0;
    logic [BYTE_W-1:0]      fourth_byte = '0;
    logic                   line_end = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [WORD_W-1:0]      pixel_word;
    logic [CNT_W-1:0]       byte_count;
    logic                   last_of_run;
    logic                   line_last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COEF_SET_W-1:0]  cfg_data = '0;

    logic                   no_idle = 1'b0;
    int                     register_writes = 0;
    pixel_scoreboard        sb = new();

    yuv422_to_rgb_converter_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .third_byte  (third_byte),
        .fourth_byte (fourth_byte),
        .line_end    (line_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_word  (pixel_word),
        .byte_count  (byte_count),
        .last_of_run (last_of_run),
        .line_last   (line_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 25);
    end

    // Results are checked before the request of the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_pixel(pixel_word, byte_count, last_of_run, line_last);
            if (in_valid && in_ready)
                sb.predict_macropixel(first_byte, second_byte, third_byte, fourth_byte,
                                      line_end);
        end
    end

    function automatic logic [COEF_SET_W-1:0] coef_set(int y, int u, int v);
        return {16'(v), 16'(u), 16'(y)};
    endfunction

    function automatic int jitter();
        return int'($urandom_range(0, 128)) - 64;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [COEF_SET_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.apply_reg(index, data);
        register_writes++;
    endtask

    task automatic send_macropixel(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                                   input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3,
                                   input logic le);
        if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        first_byte  <= b0;
        second_byte <= b1;
        third_byte  <= b2;
        fourth_byte <= b3;
        line_end    <= le;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_settings();
        write_reg(REG_SOURCE_ORDER, 48'({$urandom, $urandom}));
        write_reg(REG_DEST_FORMAT, 48'({$urandom, $urandom}));
        write_reg(REG_CHROMA_MODE, 48'({$urandom, $urandom}));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_RED_COEFS, 48'({$urandom, $urandom}));
        else
            write_reg(REG_RED_COEFS, coef_set(298 + jitter(), jitter(), 409 + jitter()));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_GREEN_COEFS, 48'({$urandom, $urandom}));
        else
            write_reg(REG_GREEN_COEFS,
                      coef_set(298 + jitter(), -100 + jitter(), -208 + jitter()));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_BLUE_COEFS, 48'({$urandom, $urandom}));
        else
            write_reg(REG_BLUE_COEFS, coef_set(298 + jitter(), 516 + jitter(), jitter()));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_INPUT_OFFSETS, 48'({$urandom, $urandom}));
        else
            write_reg(REG_INPUT_OFFSETS,
                      coef_set(-16 + jitter(), -128 + jitter(), -128 + jitter()));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [FMT_W-1:0] fmt_list[5];
        int               sent;
        int               line_len;
        logic             le;

        fmt_list = '{FMT_BGRA, FMT_BGR24, FMT_R10K, FMT_ARGB, FMT_UNUSED};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: identity gains, so every channel follows luma.
        send_macropixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_macropixel(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
        send_macropixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1);
        drain();

        write_reg(REG_SOURCE_ORDER, 48'(ORDER_UYVY));
        write_reg(REG_DEST_FORMAT, 48'(FMT_RGB24));
        write_reg(REG_CHROMA_MODE, 48'(CHROMA_AVERAGE));
        write_reg(REG_RED_COEFS, coef_set(298, 0, 409));
        write_reg(REG_GREEN_COEFS, coef_set(298, -100, -208));
        write_reg(REG_BLUE_COEFS, coef_set(298, 516, 0));
        write_reg(REG_INPUT_OFFSETS, coef_set(-16, -128, -128));
        cfg_valid <= 1'b0;
        send_macropixel(8'h80, 8'h10, 8'h80, 8'hEB, 1'b0);
        send_macropixel(8'hF0, 8'h51, 8'h5A, 8'hA0, 1'b0);
        send_macropixel(8'h10, 8'hFF, 8'hF0, 8'h00, 1'b1);
        send_macropixel(8'h80, 8'h80, 8'h80, 8'h80, 1'b1);
        send_macropixel(8'h22, 8'hB6, 8'h36, 8'h22, 1'b0);
        drain();

        // The held pixel survives these writes and leaves with the new settings.
        write_reg(REG_SOURCE_ORDER, 48'd0);
        write_reg(REG_CHROMA_MODE, 48'd0);
        write_reg(REG_DEST_FORMAT, 48'(FMT_R210));
        write_reg(REG_RED_COEFS, coef_set(32767, 32767, 32767));
        write_reg(REG_GREEN_COEFS, coef_set(-32768, -32768, -32768));
        write_reg(REG_BLUE_COEFS, coef_set(298, 516, 0));
        write_reg(REG_INPUT_OFFSETS, coef_set(32767, -32768, 0));
        cfg_valid <= 1'b0;
        send_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_macropixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_macropixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
        send_macropixel(8'hED, 8'hCB, 8'hA9, 8'h87, 1'b1);
        drain();

        write_reg(REG_CHROMA_MODE, 48'(CHROMA_AVERAGE));
        write_reg(REG_RED_COEFS, coef_set(298, 0, 409));
        write_reg(REG_GREEN_COEFS, coef_set(298, -100, -208));
        write_reg(REG_INPUT_OFFSETS, coef_set(-16, -128, -128));
        write_reg(REG_UNUSED, {48{1'b1}});
        cfg_valid <= 1'b0;
        foreach (fmt_list[i])
        begin
            write_reg(REG_DEST_FORMAT, 48'(fmt_list[i]));
            cfg_valid <= 1'b0;
            send_macropixel(8'h3C, 8'hC3, 8'h96, 8'h69, 1'b0);
            send_macropixel(8'hE1, 8'h1E, 8'h0F, 8'hF0, 1'b1);
            drain();
        end

        for (int phase = 0; phase < 10; phase++)
        begin
            no_idle <= (phase >= 4 && phase < 7);
            random_settings();
            sent = 0;
            while (sent < 25)
            begin
                line_len = $urandom_range(1, 6);
                for (int k = 0; k < line_len; k++)
                begin
                    le = (k == line_len - 1);
                    if ($urandom_range(0, 9) == 0)
                        le = $urandom_range(0, 1);
                    send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(), le);
                    sent++;
                end
            end
            drain();
        end

        $display("Ran %0d macropixels through %0d register writes and checked %0d pixels.",
                 sb.macropixels, register_writes, sb.pixels);
        $display("Both byte orders, both chroma modes, every packing layout and clip limits seen.");
        if (sb.expected_pixels.size() != 0)
        begin
            $error("%0d expected pixels never arrived", sb.expected_pixels.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d pixels outstanding.", sb.expected_pixels.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/y2r_pkg.sv
design/y2r_front.sv
design/y2r_queue.sv
design/y2r_back.sv
design/yuv422_to_rgb_converter_unit.sv
tb/yuv422_to_rgb_converter_unit_tb.sv
